// ----- hw/rtl/grcu_pkg.sv -----
// Shared types, constants and field widths for the occupancy grid ray updater.
// Depends on nothing.
package grcu_pkg;
	localparam int MAP_SIZE = 256;
	localparam int CW = $clog2(MAP_SIZE);
	localparam int AW = 2 * CW;
	localparam logic [7:0] UNKNOWN_VALUE = 8'd127;

	localparam logic [1:0] CMD_RAY = 2'd0;
	localparam logic [1:0] CMD_READ = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [2:0] ST_DRAWN = 3'd0;
	localparam logic [2:0] ST_START_OUT = 3'd1;
	localparam logic [2:0] ST_END_OUT = 3'd2;
	localparam logic [2:0] ST_ZERO = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam logic [1:0] REG_FREE_CAP = 2'd0;
	localparam logic [1:0] REG_OCC_FLOOR = 2'd1;
	localparam logic [1:0] REG_OCC_THR = 2'd2;
	localparam logic [1:0] REG_FREE_THR = 2'd3;

	localparam logic [1:0] CLS_OCC = 2'd0;
	localparam logic [1:0] CLS_UNK = 2'd1;
	localparam logic [1:0] CLS_FREE = 2'd2;

	// op kinds handed from front to back
	localparam logic [1:0] OP_REPORT = 2'd0;
	localparam logic [1:0] OP_WALK = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [2:0] status;
		logic set_flag;
		logic [CW-1:0] x0;
		logic [CW-1:0] y0;
		logic [CW-1:0] x1;
		logic [CW-1:0] y1;
		logic [CW-1:0] len;
		logic [CW-1:0] minor;
		logic sx;
		logic sy;
		logic major_x;
	} job_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] cell_value;
		logic [1:0] cell_class;
		logic outside_seen;
		logic [8:0] cells_freed;
	} res_t;
endpackage

// ----- hw/rtl/grid_ray_cast_update.sv -----
// Occupancy grid ray updater, top level.
// Channels: s_axis_* takes requests, m_axis_* returns one result each, cfg_* writes
// the four threshold registers (index 0 free_cap, 1 occupied_floor,
// 2 occupied class limit, 3 free class limit).
// A ray walks one cell at a time, with one grid read and one write on the single
// memory port for each cell, then a read and a write of the end cell.
// A clear sweeps MAP_SIZE*MAP_SIZE cells to 127, one per cycle. Requests are
// carried out one at a time.
// A two-entry queue sits between the decode front and the memory back end, so
// up to two requests are taken while a result waits.
// At reset the back end sweeps all MAP_SIZE*MAP_SIZE cells (65536) to 127 and
// takes nothing from the queue meanwhile; registers go to their defaults.
// When m_axis_tready is low the result holds and the back end stalls; the
// queue then fills and s_axis_tready drops.
// Depends on grcu_pkg, grcu_front, grcu_queue, grcu_back.
module grid_ray_cast_update import grcu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [71:0] s_axis_tdata, // cmd, start_x, start_y, end_x, end_y
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [23:0] m_axis_tdata, // status, cell_value, cell_class, outside_seen, cells_freed
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [7:0] cfg_data
);
	logic [7:0] free_cap_q, occ_floor_q, occ_thr_q, free_thr_q;
	job_t fjob, qjob;
	logic qv, qr;
	res_t r;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_cap_q <= 8'd137;
			occ_floor_q <= 8'd117;
			occ_thr_q <= 8'd127;
			free_thr_q <= 8'd127;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FREE_CAP: free_cap_q <= cfg_data;
				REG_OCC_FLOOR: occ_floor_q <= cfg_data;
				REG_OCC_THR: occ_thr_q <= cfg_data;
				REG_FREE_THR: free_thr_q <= cfg_data;
				default: free_cap_q <= free_cap_q;
			endcase
		end
	end

	grcu_front u_front (
		.cmd(s_axis_tdata[1:0]),
		.start_x(s_axis_tdata[17:2]),
		.start_y(s_axis_tdata[33:18]),
		.end_x(s_axis_tdata[49:34]),
		.end_y(s_axis_tdata[65:50]),
		.job(fjob)
	);

	grcu_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_job(fjob),
		.out_valid(qv), .out_ready(qr), .out_job(qjob)
	);

	grcu_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(qv), .job_ready(qr), .job(qjob),
		.free_cap(free_cap_q), .occupied_floor(occ_floor_q),
		.occ_limit(occ_thr_q), .free_limit(free_thr_q),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(r)
	);

	assign m_axis_tdata = {1'b0, r.cells_freed, r.outside_seen, r.cell_class,
		r.cell_value, r.status};
endmodule

// ----- hw/rtl/grcu_front.sv -----
// Front end: decodes the command, checks the ray or read point against the grid and precomputes walk setup.
// Depends on grcu_pkg.
module grcu_front import grcu_pkg::*; (
	input logic [1:0] cmd,
	input logic signed [15:0] start_x,
	input logic signed [15:0] start_y,
	input logic signed [15:0] end_x,
	input logic signed [15:0] end_y,
	output job_t job
);
	logic s_on, e_on;
	logic [CW-1:0] sxu, syu, exu, eyu, adx, ady;

	always_comb begin
		s_on = (start_x >= 0) && (start_x < MAP_SIZE) && (start_y >= 0) && (start_y < MAP_SIZE);
		e_on = (end_x >= 0) && (end_x < MAP_SIZE) && (end_y >= 0) && (end_y < MAP_SIZE);
		sxu = start_x[CW-1:0];
		syu = start_y[CW-1:0];
		exu = end_x[CW-1:0];
		eyu = end_y[CW-1:0];
		adx = (exu >= sxu) ? exu - sxu : sxu - exu;
		ady = (eyu >= syu) ? eyu - syu : syu - eyu;
		job = '0;
		job.x0 = sxu;
		job.y0 = syu;
		job.x1 = exu;
		job.y1 = eyu;
		job.sx = exu < sxu;
		job.sy = eyu < syu;
		job.major_x = adx > ady;
		job.len = job.major_x ? adx : ady;
		job.minor = job.major_x ? ady : adx;
		job.status = ST_DONE;
		job.op = OP_REPORT;
		unique case (cmd)
			CMD_RAY: begin
				if (!s_on) job.status = ST_START_OUT;
				else if (!e_on) begin
					job.status = ST_END_OUT;
					job.set_flag = 1'b1;
				end else if (sxu == exu && syu == eyu) job.status = ST_ZERO;
				else begin
					job.status = ST_DRAWN;
					job.op = OP_WALK;
				end
			end
			CMD_READ: begin
				if (!s_on) job.status = ST_START_OUT;
				else job.op = OP_READ;
			end
			CMD_CLEAR: job.op = OP_CLEAR;
			default: job.op = OP_REPORT;
		endcase
	end
endmodule

// ----- hw/rtl/grcu_queue.sv -----
// Two-entry queue between front and back ends.
// Depends on grcu_pkg.
module grcu_queue import grcu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input job_t in_job,
	output logic out_valid,
	input logic out_ready,
	output job_t out_job
);
	job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_job = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ----- hw/rtl/grcu_back.sv -----
// Back end: grid memory, walk sequencer, clear sweep and result register.
// Depends on grcu_pkg.
module grcu_back import grcu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	output logic job_ready,
	input job_t job,
	input logic [7:0] free_cap,
	input logic [7:0] occupied_floor,
	input logic [7:0] occ_limit,
	input logic [7:0] free_limit,
	output logic res_valid,
	input logic res_ready,
	output res_t res
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_WRD = 4'd1;
	localparam logic [3:0] S_WWR = 4'd2;
	localparam logic [3:0] S_ERD = 4'd3;
	localparam logic [3:0] S_EWR = 4'd4;
	localparam logic [3:0] S_RRD = 4'd5;
	localparam logic [3:0] S_RES = 4'd6;
	localparam logic [3:0] S_CLR = 4'd7;
	localparam logic [3:0] S_RVAL = 4'd8;

	logic [7:0] grid_mem [MAP_SIZE*MAP_SIZE];
	logic [7:0] rd_q;
	logic [3:0] state_q;
	logic [AW-1:0] addr_q;
	logic we;
	logic [7:0] wd;
	job_t j_q;
	logic [CW-1:0] x_q, y_q, i_q;
	logic signed [CW+2:0] err_q, err_n;
	logic flag_q;
	res_t res_q;
	res_t take_res;
	logic take;

	assign job_ready = state_q == S_IDLE;
	assign take = job_valid && job_ready;
	assign res_valid = state_q == S_RES;
	assign res = res_q;
	assign err_n = err_q + $signed({2'b0, j_q.minor, 1'b0});

	always_comb begin
		take_res = '0;
		take_res.status = job.status;
		take_res.outside_seen = (job.op == OP_CLEAR) ? 1'b0 : (flag_q | job.set_flag);
	end

	always_comb begin
		we = 1'b0;
		wd = rd_q;
		unique case (state_q)
			S_WWR: begin
				we = 1'b1;
				wd = (rd_q < free_cap) ? rd_q + 8'd1 : rd_q;
			end
			S_EWR: begin
				we = 1'b1;
				wd = (rd_q > occupied_floor) ? rd_q - 8'd1 : rd_q;
			end
			S_CLR: begin
				we = 1'b1;
				wd = UNKNOWN_VALUE;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) grid_mem[addr_q] <= wd;
		rd_q <= grid_mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			addr_q <= '0;
			flag_q <= 1'b0;
			res_q <= '0;
			j_q <= '0;
			x_q <= '0;
			y_q <= '0;
			i_q <= '0;
			err_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						j_q <= job;
						x_q <= job.x0;
						y_q <= job.y0;
						i_q <= '0;
						err_q <= -$signed({3'b0, job.len});
						res_q <= take_res;
						flag_q <= take_res.outside_seen;
						unique case (job.op)
							OP_WALK: begin
								addr_q <= {job.y0, job.x0};
								state_q <= S_WRD;
							end
							OP_READ: begin
								addr_q <= {job.y0, job.x0};
								state_q <= S_RRD;
							end
							OP_CLEAR: begin
								addr_q <= '0;
								state_q <= S_CLR;
							end
							default: state_q <= S_RES;
						endcase
					end
				end
				S_WRD: state_q <= S_WWR;
				S_WWR: begin
					logic [CW-1:0] nx, ny;
					nx = x_q;
					ny = y_q;
					if (j_q.major_x) nx = j_q.sx ? x_q - 1'b1 : x_q + 1'b1;
					else ny = j_q.sy ? y_q - 1'b1 : y_q + 1'b1;
					if (err_n > 0) begin
						err_q <= err_n - $signed({2'b0, j_q.len, 1'b0});
						if (j_q.major_x) ny = j_q.sy ? y_q - 1'b1 : y_q + 1'b1;
						else nx = j_q.sx ? x_q - 1'b1 : x_q + 1'b1;
					end else err_q <= err_n;
					x_q <= nx;
					y_q <= ny;
					i_q <= i_q + 1'b1;
					if (i_q + 1'b1 == j_q.len) begin
						addr_q <= {j_q.y1, j_q.x1};
						state_q <= S_ERD;
					end else begin
						addr_q <= {ny, nx};
						state_q <= S_WRD;
					end
				end
				S_ERD: state_q <= S_EWR;
				S_EWR: begin
					res_q.cells_freed <= {1'b0, j_q.len};
					state_q <= S_RES;
				end
				S_RRD: state_q <= S_RVAL;
				S_RVAL: begin
					res_q.cell_value <= rd_q;
					res_q.cell_class <= (rd_q < occ_limit) ? CLS_OCC :
						(rd_q > free_limit) ? CLS_FREE : CLS_UNK;
					state_q <= S_RES;
				end
				S_RES: if (res_ready) state_q <= S_IDLE;
				S_CLR: begin
					addr_q <= addr_q + 1'b1;
					if (&addr_q) state_q <= (j_q.op == OP_CLEAR) ? S_RES : S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for grid_ray_cast_update: random and directed ray, read and
// clear requests against an in-bench occupancy grid predictor, across several settings.
// Depends on grcu_pkg and the grid_ray_cast_update RTL.
`timescale 1ns / 1ps
module tb_top;
	import grcu_pkg::*;

	localparam int STALL_LIMIT = 400000;
	localparam int PHASE_ITEMS = 260;
	localparam int NUM_PHASES = 4;
	localparam logic [1:0] CMD_SPARE = 2'd3;

	typedef struct {
		logic [1:0] cmd;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic signed [15:0] ex;
		logic signed [15:0] ey;
	} request_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	logic [7:0] grid_model [MAP_SIZE*MAP_SIZE];
	logic outside_model;
	logic [7:0] cap_q, floor_q, occ_thr_q, free_thr_q;

	request_t pending_reqs[$];
	res_t expected_results[$];
	int sent_count, taken_count;
	int burst_left, gap_left;
	int rx_mode, rx_cycle, rx_stall;
	int quiet_cycles;
	int errors;
	int clears_left;
	int win_x, win_y;

	grid_ray_cast_update dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit on_map(int x, int y);
		return x >= 0 && x < MAP_SIZE && y >= 0 && y < MAP_SIZE;
	endfunction

	function automatic res_t apply_command(request_t r);
		res_t o;
		int x0, y0, x1, y1, dx, dy, adx, ady, stx, sty, len, minor, err, x, y;
		bit major_x;
		o = '0;
		o.status = ST_DONE;
		x0 = r.sx; y0 = r.sy; x1 = r.ex; y1 = r.ey;
		if (r.cmd == CMD_RAY) begin
			if (!on_map(x0, y0)) begin
				o.status = ST_START_OUT;
			end else if (!on_map(x1, y1)) begin
				outside_model = 1'b1;
				o.status = ST_END_OUT;
			end else if (x0 == x1 && y0 == y1) begin
				o.status = ST_ZERO;
			end else begin
				dx = x1 - x0; dy = y1 - y0;
				adx = dx < 0 ? -dx : dx;
				ady = dy < 0 ? -dy : dy;
				stx = dx < 0 ? -1 : 1;
				sty = dy < 0 ? -1 : 1;
				major_x = adx > ady;
				len = major_x ? adx : ady;
				minor = major_x ? ady : adx;
				err = -len;
				x = x0; y = y0;
				for (int i = 0; i < len; i++) begin
					if (on_map(x, y) && grid_model[y*MAP_SIZE+x] < cap_q)
						grid_model[y*MAP_SIZE+x] = grid_model[y*MAP_SIZE+x] + 8'd1;
					err += 2 * minor;
					if (major_x) x += stx; else y += sty;
					if (err > 0) begin
						err -= 2 * len;
						if (major_x) y += sty; else x += stx;
					end
				end
				if (grid_model[y1*MAP_SIZE+x1] > floor_q)
					grid_model[y1*MAP_SIZE+x1] = grid_model[y1*MAP_SIZE+x1] - 8'd1;
				o.cells_freed = len[8:0];
				o.status = ST_DRAWN;
			end
		end else if (r.cmd == CMD_READ) begin
			if (!on_map(x0, y0)) begin
				o.status = ST_START_OUT;
			end else begin
				o.cell_value = grid_model[y0*MAP_SIZE+x0];
				if (o.cell_value < occ_thr_q) o.cell_class = CLS_OCC;
				else if (o.cell_value > free_thr_q) o.cell_class = CLS_FREE;
				else o.cell_class = CLS_UNK;
			end
		end else if (r.cmd == CMD_CLEAR) begin
			foreach (grid_model[i]) grid_model[i] = UNKNOWN_VALUE;
			outside_model = 1'b0;
		end
		o.outside_seen = outside_model;
		return o;
	endfunction

	task automatic queue_req(logic [1:0] c, int sx, int sy, int ex, int ey);
		request_t r;
		r.cmd = c;
		r.sx = sx[15:0]; r.sy = sy[15:0]; r.ex = ex[15:0]; r.ey = ey[15:0];
		pending_reqs.push_back(r);
	endtask

	task automatic wait_idle();
		wait (pending_reqs.size() == 0 && sent_count == taken_count
			&& expected_results.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_FREE_CAP: cap_q = val;
			REG_OCC_FLOOR: floor_q = val;
			REG_OCC_THR: occ_thr_q = val;
			default: free_thr_q = val;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic int rand_coord16();
		return $signed($urandom_range(0, 16'hFFFF) - 32768);
	endfunction

	task automatic queue_random();
		int kind, sel, x0, y0, x1, y1;
		kind = $urandom_range(0, 99);
		if ($urandom_range(0, 40) == 0) begin
			win_x = $urandom_range(0, MAP_SIZE - 16);
			win_y = $urandom_range(0, MAP_SIZE - 16);
		end
		if (kind < 2) begin
			queue_req(CMD_SPARE, rand_coord16(), rand_coord16(), rand_coord16(),
				rand_coord16());
		end else if (kind < 3 && clears_left > 0) begin
			clears_left--;
			queue_req(CMD_CLEAR, rand_coord16(), rand_coord16(), rand_coord16(),
				rand_coord16());
		end else if (kind < 35) begin
			if ($urandom_range(0, 9) < 8)
				queue_req(CMD_READ, win_x + $urandom_range(0, 15), win_y + $urandom_range(0, 15),
					rand_coord16(), rand_coord16());
			else
				queue_req(CMD_READ, rand_coord16(), rand_coord16(), rand_coord16(),
					rand_coord16());
		end else begin
			sel = $urandom_range(0, 99);
			if (sel < 72) begin
				x0 = win_x + $urandom_range(0, 15); y0 = win_y + $urandom_range(0, 15);
				x1 = win_x + $urandom_range(0, 15); y1 = win_y + $urandom_range(0, 15);
			end else if (sel < 84) begin
				x0 = $urandom_range(0, MAP_SIZE - 1); y0 = $urandom_range(0, MAP_SIZE - 1);
				x1 = $urandom_range(0, MAP_SIZE - 1); y1 = $urandom_range(0, MAP_SIZE - 1);
			end else if (sel < 92) begin
				x0 = win_x + $urandom_range(0, 15); y0 = win_y + $urandom_range(0, 15);
				x1 = $urandom_range(0, 1) ? rand_coord16() : -1 - $urandom_range(0, 3);
				y1 = rand_coord16();
			end else begin
				x0 = rand_coord16(); y0 = rand_coord16();
				x1 = rand_coord16(); y1 = rand_coord16();
			end
			queue_req(CMD_RAY, x0, y0, x1, y1);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_FREE_CAP;
		cfg_data = '0;
		cap_q = 8'd137; floor_q = 8'd117; occ_thr_q = 8'd127; free_thr_q = 8'd127;
		foreach (grid_model[i]) grid_model[i] = UNKNOWN_VALUE;
		outside_model = 1'b0;
		errors = 0;
		clears_left = 4;
		win_x = 8; win_y = 8;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(REG_FREE_CAP, 8'd137);
		write_reg(REG_OCC_FLOOR, 8'd117);
		write_reg(REG_OCC_THR, 8'd127);
		write_reg(REG_FREE_THR, 8'd127);

		queue_req(CMD_READ, 0, 0, 0, 0);
		queue_req(CMD_RAY, 0, 0, 255, 255);
		queue_req(CMD_RAY, 255, 0, 0, 0);
		queue_req(CMD_RAY, 0, 255, 0, 0);
		queue_req(CMD_RAY, 10, 10, 13, 20);
		queue_req(CMD_RAY, 20, 20, 12, 17);
		queue_req(CMD_RAY, 5, 5, 5, 5);
		queue_req(CMD_RAY, -1, 0, 3, 3);
		queue_req(CMD_RAY, 0, 256, 3, 3);
		queue_req(CMD_RAY, 32767, -32768, 0, 0);
		queue_req(CMD_RAY, 3, 3, 256, 3);
		queue_req(CMD_RAY, 3, 3, -32768, 32767);
		queue_req(CMD_READ, 255, 255, 0, 0);
		queue_req(CMD_READ, -32768, 32767, 0, 0);
		queue_req(CMD_READ, 256, 0, 0, 0);
		queue_req(CMD_SPARE, -1, -1, -1, -1);
		queue_req(CMD_READ, 10, 10, 0, 0);
		queue_req(CMD_READ, 13, 20, 0, 0);
		queue_req(CMD_CLEAR, 0, 0, 0, 0);
		queue_req(CMD_READ, 0, 0, 0, 0);
		queue_req(CMD_RAY, 255, 255, 0, 0);
		queue_req(CMD_READ, 128, 128, 0, 0);
		queue_req(CMD_READ, 0, 0, 0, 0);

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			case (p)
				0: begin
					write_reg(REG_FREE_CAP, 8'd255); write_reg(REG_OCC_FLOOR, 8'd0);
					write_reg(REG_OCC_THR, 8'd0); write_reg(REG_FREE_THR, 8'd255);
				end
				1: begin
					write_reg(REG_FREE_CAP, 8'd0); write_reg(REG_OCC_FLOOR, 8'd255);
					write_reg(REG_OCC_THR, 8'd255); write_reg(REG_FREE_THR, 8'd0);
				end
				2: begin
					write_reg(REG_FREE_CAP, 8'd132); write_reg(REG_OCC_FLOOR, 8'd122);
					write_reg(REG_OCC_THR, 8'd125); write_reg(REG_FREE_THR, 8'd129);
				end
				default: begin
					write_reg(REG_FREE_CAP, 8'($urandom_range(0, 255)));
					write_reg(REG_OCC_FLOOR, 8'($urandom_range(0, 255)));
					write_reg(REG_OCC_THR, 8'($urandom_range(0, 255)));
					write_reg(REG_FREE_THR, 8'($urandom_range(0, 255)));
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) queue_random();
		end

		wait_idle();
		repeat (600) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	always @(negedge clk) begin
		if (sent_count == taken_count) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				request_t r;
				r = pending_reqs.pop_front();
				s_axis_tdata <= {6'b0, r.ey, r.ex, r.sy, r.sx, r.cmd};
				s_axis_tvalid <= 1'b1;
				sent_count <= sent_count + 1;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 20);
					gap_left <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 64 == 63) rx_mode <= $urandom_range(0, 2);
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= $urandom_range(0, 1);
			default: begin
				if (rx_stall > 0) begin
					rx_stall <= rx_stall - 1;
					m_axis_tready <= 1'b0;
				end else begin
					rx_stall <= $urandom_range(0, 10);
					m_axis_tready <= 1'b1;
				end
			end
		endcase
	end

	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (s_axis_tvalid && s_axis_tready) begin
			request_t r;
			r.cmd = s_axis_tdata[1:0];
			r.sx = s_axis_tdata[17:2];
			r.sy = s_axis_tdata[33:18];
			r.ex = s_axis_tdata[49:34];
			r.ey = s_axis_tdata[65:50];
			expected_results.push_back(apply_command(r));
			taken_count <= taken_count + 1;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tdata[2:0];
			got.cell_value = m_axis_tdata[10:3];
			got.cell_class = m_axis_tdata[12:11];
			got.outside_seen = m_axis_tdata[13];
			got.cells_freed = m_axis_tdata[22:14];
			if (expected_results.size() == 0) begin
				$error("unexpected result %h", m_axis_tdata);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status) begin
					$error("status exp %0d got %0d", want.status, got.status); errors++;
				end
				if (got.cell_value !== want.cell_value) begin
					$error("cell_value exp %0d got %0d", want.cell_value, got.cell_value);
					errors++;
				end
				if (got.cell_class !== want.cell_class) begin
					$error("cell_class exp %0d got %0d", want.cell_class, got.cell_class);
					errors++;
				end
				if (got.outside_seen !== want.outside_seen) begin
					$error("outside_seen exp %0d got %0d", want.outside_seen, got.outside_seen);
					errors++;
				end
				if (got.cells_freed !== want.cells_freed) begin
					$error("cells_freed exp %0d got %0d", want.cells_freed, got.cells_freed);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		sent_count = 0; taken_count = 0;
		burst_left = 0; gap_left = 0;
		rx_mode = 0; rx_cycle = 0; rx_stall = 0;
		quiet_cycles = 0;
	end
endmodule
